// File: hdl/qrm_pkg.sv
`default_nettype none

package qrm_pkg;

  // Component width and the widths derived from it.
  localparam int unsigned CW  = 32;
  localparam int unsigned PW  = 2 * CW;   // product of two components
  localparam int unsigned NW  = PW + 2;   // squared norm, sum of four squares
  localparam int unsigned FSW = PW + 3;   // signed quadratic form
  localparam int unsigned QW  = 31;       // quotient bits, the result is at most 2^30
  localparam int unsigned OW  = 32;       // Q1.30 output entry
  localparam int unsigned NE  = 9;        // matrix entries

  // One item on its way through the divider stages.
  typedef struct packed {
    logic                   zero;
    logic [NW-1:0]          n2;
    logic [NE-1:0]          neg;
    logic [NE-1:0][NW-1:0]  rem;
    logic [NE-1:0][QW-1:0]  qn;
  } div_t;

endpackage

`default_nettype wire

// File: hdl/qrm_forms.sv
`default_nettype none

module qrm_forms (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [qrm_pkg::CW-1:0]      comp_w_i,
  input  logic [qrm_pkg::CW-1:0]      comp_x_i,
  input  logic [qrm_pkg::CW-1:0]      comp_y_i,
  input  logic [qrm_pkg::CW-1:0]      comp_z_i,
  output logic                        valid_o,
  output qrm_pkg::div_t               div_o
);
  import qrm_pkg::*;

  logic signed [CW-1:0] a, b, c, d;
  logic signed [PW-1:0] sq_d [4];
  logic signed [PW-1:0] pr_d [6];
  logic signed [PW-1:0] sq_q [4];
  logic signed [PW-1:0] pr_q [6];
  logic signed [FSW-1:0] f_d [NE];
  logic signed [FSW-1:0] f_q [NE];
  logic [NW-1:0] n2_d, n2_q;
  logic vld_a_q, vld_b_q, vld_c_q;
  div_t div_d, div_q;

  assign a = comp_w_i;
  assign b = comp_x_i;
  assign c = comp_y_i;
  assign d = comp_z_i;

  // Stage one: the four squares and six cross products.
  always_comb begin
    sq_d[0] = a * a;
    sq_d[1] = b * b;
    sq_d[2] = c * c;
    sq_d[3] = d * d;
    pr_d[0] = a * b;
    pr_d[1] = a * c;
    pr_d[2] = a * d;
    pr_d[3] = b * c;
    pr_d[4] = b * d;
    pr_d[5] = c * d;
  end

  // Stage two: the nine quadratic forms and the squared norm.
  always_comb begin
    n2_d = NW'(sq_q[0]) + NW'(sq_q[1]) + NW'(sq_q[2]) + NW'(sq_q[3]);
    f_d[0] = FSW'(sq_q[0]) + FSW'(sq_q[1]) - FSW'(sq_q[2]) - FSW'(sq_q[3]);
    f_d[1] = FSW'(pr_q[3]) - FSW'(pr_q[2]);
    f_d[2] = FSW'(pr_q[4]) + FSW'(pr_q[1]);
    f_d[3] = FSW'(pr_q[3]) + FSW'(pr_q[2]);
    f_d[4] = FSW'(sq_q[0]) - FSW'(sq_q[1]) + FSW'(sq_q[2]) - FSW'(sq_q[3]);
    f_d[5] = FSW'(pr_q[5]) - FSW'(pr_q[0]);
    f_d[6] = FSW'(pr_q[4]) - FSW'(pr_q[1]);
    f_d[7] = FSW'(pr_q[5]) + FSW'(pr_q[0]);
    f_d[8] = FSW'(sq_q[0]) - FSW'(sq_q[1]) - FSW'(sq_q[2]) + FSW'(sq_q[3]);
  end

  // Stage three: sign and magnitude, and the divider's starting remainder.
  // The quotient fits in QW bits, so the numerator's bits above those
  // start out in the remainder directly.
  always_comb begin
    logic [FSW-1:0] mag;
    div_d.zero = (n2_q == '0);
    div_d.n2   = n2_q;
    for (int i = 0; i < NE; i++) begin
      div_d.neg[i] = f_q[i][FSW-1];
      mag = f_q[i][FSW-1] ? FSW'(-f_q[i]) : FSW'(f_q[i]);
      if (i == 0 || i == 4 || i == 8) begin
        div_d.rem[i] = mag[NW:1];
        div_d.qn[i]  = {mag[0], (QW-1)'(0)};
      end else begin
        div_d.rem[i] = mag[NW-1:0];
        div_d.qn[i]  = '0;
      end
    end
  end

  // Data registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q  <= sq_d;
      pr_q  <= pr_d;
      f_q   <= f_d;
      n2_q  <= n2_d;
      div_q <= div_d;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
    end else if (en_i) begin
      vld_a_q <= valid_i;
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
    end
  end

  assign valid_o = vld_c_q;
  assign div_o   = div_q;

endmodule

`default_nettype wire

// File: hdl/qrm_div_stage.sv
`default_nettype none

module qrm_div_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  qrm_pkg::div_t  div_i,
  output logic           valid_o,
  output qrm_pkg::div_t  div_o
);
  import qrm_pkg::*;

  div_t div_d, div_q;
  logic vld_q;

  // One restoring step on each of the nine lanes: bring down the next
  // numerator bit, subtract the norm where it fits, shift in the bit.
  always_comb begin
    logic [NW:0] t;
    logic        ge;
    div_d = div_i;
    for (int i = 0; i < NE; i++) begin
      t  = {div_i.rem[i], div_i.qn[i][QW-1]};
      ge = (t >= {1'b0, div_i.n2});
      div_d.rem[i] = ge ? NW'(t - {1'b0, div_i.n2}) : NW'(t);
      div_d.qn[i]  = {div_i.qn[i][QW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= valid_i;
    end
  end

  assign valid_o = vld_q;
  assign div_o   = div_q;

endmodule

`default_nettype wire

// File: hdl/quaternion_to_rotation_matrix.sv
// An accepted input beat reaches its output beat through
// three stages of products and forms, 31 divider steps and one rounding stage.
// Throughput: one beat per cycle; the whole pipeline holds while the output
// beat waits. Reset clears only the valid bits, so the pipeline comes up empty.
`default_nettype none

module quaternion_to_rotation_matrix (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // comp_w, comp_x, comp_y, comp_z from the lowest bit up
  input  logic [4*qrm_pkg::CW-1:0]       s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22 from the lowest bit up
  output logic [qrm_pkg::NE*qrm_pkg::OW-1:0] m_axis_tdata_o,
  // zero_norm
  output logic                           m_axis_tuser_o
);
  import qrm_pkg::*;

  logic en;
  logic vld [QW+1];
  div_t stg [QW+1];
  logic [NE-1:0][OW-1:0] m_d, m_q;
  logic zero_q, out_vld_q;

  // The pipeline moves whenever the output register is free or being read.
  assign en = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  qrm_forms u_forms (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_axis_tvalid_i),
    .comp_w_i (s_axis_tdata_i[CW-1:0]),
    .comp_x_i (s_axis_tdata_i[2*CW-1:CW]),
    .comp_y_i (s_axis_tdata_i[3*CW-1:2*CW]),
    .comp_z_i (s_axis_tdata_i[4*CW-1:3*CW]),
    .valid_o  (vld[0]),
    .div_o    (stg[0])
  );

  // Divider, one quotient bit per stage.
  for (genvar g = 0; g < QW; g++) begin : g_div
    qrm_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vld[g]),
      .div_i   (stg[g]),
      .valid_o (vld[g+1]),
      .div_o   (stg[g+1])
    );
  end

  // Round to nearest, ties away from zero, then apply the sign; a zero norm gives all-zero entries.
  always_comb begin
    logic [OW-1:0] q;
    logic          up;
    for (int i = 0; i < NE; i++) begin
      up = ({stg[QW].rem[i], 1'b0} >= {1'b0, stg[QW].n2});
      q  = OW'(stg[QW].qn[i]) + OW'(up);
      if (stg[QW].zero) begin
        m_d[i] = '0;
      end else if (stg[QW].neg[i]) begin
        m_d[i] = OW'(-q);
      end else begin
        m_d[i] = q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_q    <= m_d;
      zero_q <= stg[QW].zero;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld[QW];
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = m_q;
  assign m_axis_tuser_o  = zero_q;

endmodule

`default_nettype wire
